### design/pearson_correlation_unit_assert.svh
// Assertion macros used by the checker file.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef PEARSON_CORRELATION_UNIT_ASSERT_SVH
`define PEARSON_CORRELATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PCORR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcorr: same-cycle check failed");

// Next-cycle implication.
`define PCORR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcorr: next-cycle check failed");

`endif

### design/pcorr_pkg.sv
package pcorr_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned MAX_COUNT_DEF   = 4096;
  localparam int unsigned CORR_W          = 16;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned PAIR_W          = 13;
  localparam int unsigned FRAC_BITS       = 15;
  localparam int unsigned QUO_W           = FRAC_BITS + 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_OVERFLOW = 2'd2
  } pcorr_status_e;

  // Multiply schedule for the final reduction.
  typedef enum logic [2:0] {
    OP_N_SXY = 3'd0,
    OP_SX_SY = 3'd1,
    OP_N_SXX = 3'd2,
    OP_SX_SX = 3'd3,
    OP_N_SYY = 3'd4,
    OP_SY_SY = 3'd5,
    OP_DX_DY = 3'd6
  } pcorr_op_e;

  typedef struct packed {
    logic          acc_en;
    logic          mul_load;
    logic          mul_run;
    logic          mul_wb;
    pcorr_op_e     op;
    logic          sq_load;
    logic          sq_run;
    logic          dv_load;
    logic          dv_run;
    logic          out_load;
    pcorr_status_e out_status;
  } pcorr_cmd_t;

  typedef struct packed {
    logic ovf;
    logic var_zero;
    logic step_last;
  } pcorr_sts_t;

endpackage

### design/pcorr_if.sv
interface pcorr_in_if #(
  parameter int unsigned SAMPLE_BITS = pcorr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] x_sample;
  logic signed [SAMPLE_BITS-1:0] y_sample;
  logic                          last;

  modport source (output valid, x_sample, y_sample, last, input ready);
  modport sink   (input valid, x_sample, y_sample, last, output ready);
endinterface

interface pcorr_out_if;
  import pcorr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] corr_q15;
  logic [STATUS_W-1:0]      status;
  logic [PAIR_W-1:0]        pair_count;

  modport source (output valid, corr_q15, status, pair_count, input ready);
  modport sink   (input valid, corr_q15, status, pair_count, output ready);
endinterface

### design/pcorr_ctrl.sv
module pcorr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  input  pcorr_pkg::pcorr_sts_t  sts_i,
  output pcorr_pkg::pcorr_cmd_t  cmd_o
);
  import pcorr_pkg::*;

  typedef enum logic [10:0] {
    S_ACC    = 11'b000_0000_0001,
    S_CHK    = 11'b000_0000_0010,
    S_MLOAD  = 11'b000_0000_0100,
    S_MRUN   = 11'b000_0000_1000,
    S_MWB    = 11'b000_0001_0000,
    S_VCHK   = 11'b000_0010_0000,
    S_SQLOAD = 11'b000_0100_0000,
    S_SQRUN  = 11'b000_1000_0000,
    S_DVLOAD = 11'b001_0000_0000,
    S_DVRUN  = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e        state_q, state_d;
  pcorr_op_e     op_q, op_d;
  pcorr_status_e stat_q, stat_d;
  logic          out_valid_q, out_valid_d;
  logic          accept;

  assign in_ready_o  = (state_q == S_ACC);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    stat_d      = stat_q;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    cmd_o.out_status = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_ACC: begin
        cmd_o.acc_en = accept;
        if (accept && in_last_i) state_d = S_CHK;
      end
      S_CHK: begin
        op_d = OP_N_SXY;
        if (sts_i.ovf) begin
          stat_d  = ST_OVERFLOW;
          state_d = S_OUT;
        end else begin
          state_d = S_MLOAD;
        end
      end
      S_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        state_d = S_MRUN;
      end
      S_MRUN: begin
        cmd_o.mul_run = 1'b1;
        if (sts_i.step_last) state_d = S_MWB;
      end
      S_MWB: begin
        cmd_o.mul_wb = 1'b1;
        unique case (op_q)
          OP_N_SXY: begin op_d = OP_SX_SY; state_d = S_MLOAD; end
          OP_SX_SY: begin op_d = OP_N_SXX; state_d = S_MLOAD; end
          OP_N_SXX: begin op_d = OP_SX_SX; state_d = S_MLOAD; end
          OP_SX_SX: begin op_d = OP_N_SYY; state_d = S_MLOAD; end
          OP_N_SYY: begin op_d = OP_SY_SY; state_d = S_MLOAD; end
          OP_SY_SY: state_d = S_VCHK;
          default:  state_d = S_SQLOAD;
        endcase
      end
      S_VCHK: begin
        if (sts_i.var_zero) begin
          stat_d  = ST_ZERO_VAR;
          state_d = S_OUT;
        end else begin
          op_d    = OP_DX_DY;
          state_d = S_MLOAD;
        end
      end
      S_SQLOAD: begin
        cmd_o.sq_load = 1'b1;
        state_d = S_SQRUN;
      end
      S_SQRUN: begin
        cmd_o.sq_run = 1'b1;
        if (sts_i.step_last) state_d = S_DVLOAD;
      end
      S_DVLOAD: begin
        cmd_o.dv_load = 1'b1;
        state_d = S_DVRUN;
      end
      S_DVRUN: begin
        cmd_o.dv_run = 1'b1;
        if (sts_i.step_last) begin
          stat_d  = ST_OK;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      op_q        <= OP_N_SXY;
      stat_q      <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### design/pcorr_datapath.sv
module pcorr_datapath #(
  parameter int unsigned SAMPLE_BITS = pcorr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_COUNT   = pcorr_pkg::MAX_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcorr_pkg::pcorr_cmd_t               cmd_i,
  output pcorr_pkg::pcorr_sts_t               sts_o,
  input  logic signed [SAMPLE_BITS-1:0]       x_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       y_sample_i,
  output logic signed [pcorr_pkg::CORR_W-1:0] corr_q15_o,
  output logic [pcorr_pkg::STATUS_W-1:0]      status_o,
  output logic [pcorr_pkg::PAIR_W-1:0]        pair_count_o
);
  import pcorr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam int unsigned SW = SAMPLE_BITS + CW;
  localparam int unsigned QW = 2 * SAMPLE_BITS + CW;
  localparam int unsigned PW = 2 * SAMPLE_BITS + 2 * CW + 1;
  localparam int unsigned DW = PW + FRAC_BITS;
  localparam int unsigned NW = $clog2(DW + 1);
  localparam logic [QUO_W-1:0] Q_ONE = QUO_W'(1) << FRAC_BITS;
  localparam logic [QUO_W-1:0] Q_MAX = Q_ONE - QUO_W'(1);

  // accumulators
  logic [CW-1:0]        count_q;
  logic                 ovf_q;
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic signed [QW-1:0] sum_xx_q, sum_yy_q, sum_xy_q;
  logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

  // reduction
  logic signed [PW-1:0] t_q, num_q, dx_q, dy_q;
  logic signed [PW-1:0] opa, opb;
  logic [PW-1:0]        mag_a, mag_b, pn;
  logic [PW-1:0]        mcand_q;
  logic [2*PW-1:0]      prod_q;
  logic [PW:0]          madd;
  logic                 neg_q;

  logic [2*PW-1:0]      sq_n_q, sq_res_q, sq_bit_q, sq_t;
  logic                 sq_ge;

  logic [DW-1:0]        dvd_q;
  logic [PW-1:0]        rem_q, dsor;
  logic [PW:0]          remx;
  logic                 dv_ge;
  logic [QUO_W-1:0]     quo_q, qsat;
  logic                 big_q, nneg_q;
  logic [NW-1:0]        cnt_q;

  logic signed [CORR_W-1:0] corr_q, r_val;
  logic [STATUS_W-1:0]      status_q;
  logic [PAIR_W-1:0]        pcount_q;

  assign xx = x_sample_i * x_sample_i;
  assign yy = y_sample_i * y_sample_i;
  assign xy = x_sample_i * y_sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
    end else if (cmd_i.out_load) begin
      count_q  <= '0;
      ovf_q    <= 1'b0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (count_q >= CW'(MAX_COUNT)) begin
        ovf_q <= 1'b1;
      end else begin
        count_q  <= count_q + CW'(1);
        sum_x_q  <= sum_x_q + SW'(x_sample_i);
        sum_y_q  <= sum_y_q + SW'(y_sample_i);
        sum_xx_q <= sum_xx_q + QW'(xx);
        sum_yy_q <= sum_yy_q + QW'(yy);
        sum_xy_q <= sum_xy_q + QW'(xy);
      end
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_N_SXY: begin opa = PW'(count_q); opb = PW'(sum_xy_q); end
      OP_SX_SY: begin opa = PW'(sum_x_q); opb = PW'(sum_y_q);  end
      OP_N_SXX: begin opa = PW'(count_q); opb = PW'(sum_xx_q); end
      OP_SX_SX: begin opa = PW'(sum_x_q); opb = PW'(sum_x_q);  end
      OP_N_SYY: begin opa = PW'(count_q); opb = PW'(sum_yy_q); end
      OP_SY_SY: begin opa = PW'(sum_y_q); opb = PW'(sum_y_q);  end
      default:  begin opa = dx_q;         opb = dy_q;          end
    endcase
  end

  assign mag_a = opa[PW-1] ? PW'(-opa) : PW'(opa);
  assign mag_b = opb[PW-1] ? PW'(-opb) : PW'(opb);
  assign madd  = {1'b0, prod_q[2*PW-1:PW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign pn    = prod_q[PW-1:0];

  assign sq_t  = sq_res_q + sq_bit_q;
  assign sq_ge = sq_n_q >= sq_t;

  assign dsor  = sq_res_q[PW-1:0];
  assign remx  = {rem_q, dvd_q[DW-1]};
  assign dv_ge = remx >= {1'b0, dsor};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      mcand_q <= mag_a;
      prod_q  <= {{PW{1'b0}}, mag_b};
      neg_q   <= opa[PW-1] ^ opb[PW-1];
      cnt_q   <= NW'(PW);
    end
    if (cmd_i.mul_run) begin
      prod_q <= {madd, prod_q[PW-1:1]};
      cnt_q  <= cnt_q - NW'(1);
    end
    if (cmd_i.mul_wb) begin
      case (cmd_i.op)
        OP_N_SXY, OP_N_SXX, OP_N_SYY: t_q <= neg_q ? PW'(-pn) : pn;
        OP_SX_SY: num_q <= neg_q ? t_q + pn : t_q - pn;
        OP_SX_SX: dx_q  <= neg_q ? t_q + pn : t_q - pn;
        OP_SY_SY: dy_q  <= neg_q ? t_q + pn : t_q - pn;
        default: ;
      endcase
    end
    if (cmd_i.sq_load) begin
      sq_n_q   <= prod_q;
      sq_res_q <= '0;
      sq_bit_q <= (2*PW)'(1) << (2*PW - 2);
      cnt_q    <= NW'(PW);
    end
    if (cmd_i.sq_run) begin
      if (sq_ge) begin
        sq_n_q   <= sq_n_q - sq_t;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
      cnt_q    <= cnt_q - NW'(1);
    end
    if (cmd_i.dv_load) begin
      nneg_q <= num_q[PW-1];
      dvd_q  <= {(num_q[PW-1] ? PW'(-num_q) : PW'(num_q)), {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      quo_q  <= '0;
      big_q  <= 1'b0;
      cnt_q  <= NW'(DW);
    end
    if (cmd_i.dv_run) begin
      rem_q <= dv_ge ? PW'(remx - {1'b0, dsor}) : remx[PW-1:0];
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[QUO_W-2:0], dv_ge};
      big_q <= big_q | quo_q[QUO_W-1];
      cnt_q <= cnt_q - NW'(1);
    end
    if (cmd_i.out_load) begin
      corr_q   <= (cmd_i.out_status == ST_OK) ? r_val : '0;
      status_q <= cmd_i.out_status;
      pcount_q <= PAIR_W'(count_q);
    end
  end

  // saturate the quotient at one, then apply the sign; a positive result is capped just below one
  always_comb begin
    qsat = (big_q || quo_q > Q_ONE) ? Q_ONE : quo_q;
    if (nneg_q) begin
      r_val = CORR_W'(-qsat);
    end else begin
      r_val = (qsat > Q_MAX) ? CORR_W'(Q_MAX) : CORR_W'(qsat);
    end
  end

  assign sts_o.ovf       = ovf_q;
  assign sts_o.var_zero  = (dx_q == '0) || (dy_q == '0);
  assign sts_o.step_last = (cnt_q == NW'(1));

  assign corr_q15_o   = corr_q;
  assign status_o     = status_q;
  assign pair_count_o = pcount_q;

endmodule

### design/pearson_correlation_unit.sv
// Streaming Pearson correlation in Q1.15. Each accepted (x, y) request, up
// to MAX_COUNT of them, is added to the running count and the sums of x, y,
// x*x, y*y and x*y, so a series streams in at one pair per clock. The
// request flagged last closes the series: after an overflow check the unit
// forms n*Sxy - Sx*Sy, n*Sxx - Sx^2 and n*Syy - Sy^2 with a shared
// shift-add multiplier (seven products), checks the variances, takes an
// integer square root of dx*dy one result bit per cycle, divides one
// quotient bit per cycle and loads the output register. Multiplier
// operands are PW bits wide, PW = 2*SAMPLE_BITS + 2*ceil(log2(MAX_COUNT+1))
// + 1. No request is taken from the last pair until that output load; a
// zero-variance or overflowed series finishes early. One result leaves
// through an output register, so the next series may start while that
// result still waits. Status is 0 for a valid coefficient, 1 when either
// variance is zero (r = 0), and 2 when more than MAX_COUNT pairs arrived
// (r = 0, pair_count = MAX_COUNT).
module pearson_correlation_unit #(
  parameter int unsigned SAMPLE_BITS = pcorr_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned MAX_COUNT   = pcorr_pkg::MAX_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcorr_in_if.sink     in_i,
  pcorr_out_if.source  out_o
);
  import pcorr_pkg::*;

  pcorr_cmd_t cmd;
  pcorr_sts_t sts;

  // Sequencer: accumulate, then walk the multiply, root and divide steps.
  pcorr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Accumulators, shared multiplier, square root and divider.
  pcorr_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COUNT   (MAX_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .x_sample_i   (in_i.x_sample),
    .y_sample_i   (in_i.y_sample),
    .corr_q15_o   (out_o.corr_q15),
    .status_o     (out_o.status),
    .pair_count_o (out_o.pair_count)
  );

endmodule

### design/pcorr_checker.sv
`include "pearson_correlation_unit_assert.svh"

module pcorr_checker #(
  parameter int unsigned MAX_COUNT = pcorr_pkg::MAX_COUNT_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_last_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [pcorr_pkg::CORR_W-1:0] out_corr_i,
  input logic [pcorr_pkg::STATUS_W-1:0]      out_status_i,
  input logic [pcorr_pkg::PAIR_W-1:0]        out_count_i
);
  import pcorr_pkg::*;

  `PCORR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_corr_i) && $stable(out_status_i) && $stable(out_count_i))
  `PCORR_ASSERT_IMP(a_ready_drop, $fell(in_ready_i), $past(in_valid_i && in_last_i))
  `PCORR_ASSERT_IMP(a_result_busy, $rose(out_valid_i), !$past(in_ready_i))
  `PCORR_ASSERT_IMP(a_bad_zero, out_valid_i && out_status_i != ST_OK, out_corr_i == '0)
  `PCORR_ASSERT_IMP(a_ovf_count, out_valid_i && out_status_i == ST_OVERFLOW, out_count_i == PAIR_W'(MAX_COUNT))

endmodule

bind pearson_correlation_unit pcorr_checker #(
  .MAX_COUNT (MAX_COUNT)
) u_pcorr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_last_i    (in_i.last),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_corr_i   (out_o.corr_q15),
  .out_status_i (out_o.status),
  .out_count_i  (out_o.pair_count)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pcorr_pkg::*;

  localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int unsigned MAX_COUNT   = MAX_COUNT_DEF;
  // Idle time at the end, meant to cover the finish path after a last request.
  localparam int unsigned FINISH_CYCLES = 700;
  localparam int unsigned CYCLE_LIMIT   = 10000000;

  typedef struct {
    logic signed [CORR_W-1:0] corr;
    pcorr_status_e            status;
    logic [PAIR_W-1:0]        pairs;
  } corr_result_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    logic               typed;
    corr_result_t       res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pcorr_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  pcorr_out_if out_if ();

  pearson_correlation_unit #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_COUNT  (MAX_COUNT)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Series state of the predictor.
  int unsigned  ser_count;
  longint       ser_sx, ser_sy, ser_sxx, ser_syy, ser_sxy;
  bit           ser_ovf;

  corr_result_t pending_corr[$];
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  stall_pct;
  int unsigned  idle_pct;
  int unsigned  hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Integer square root, one result bit per pass.
  function automatic logic [127:0] root_floor(logic [127:0] v);
    logic [127:0] res;
    logic [127:0] bitv;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0 && bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void clear_series();
    ser_count = 0;
    ser_sx = 0; ser_sy = 0; ser_sxx = 0; ser_syy = 0; ser_sxy = 0;
    ser_ovf = 1'b0;
  endfunction

  // Fold one request into the series; return 1 with the coefficient on last.
  function automatic bit fold_pair(logic signed [15:0] x, logic signed [15:0] y,
                                   logic last, output corr_result_t res);
    logic signed [127:0] n_w, num, dx, dy, mag;
    logic [127:0]        root, quo;
    longint              xs, ys;
    xs = x;
    ys = y;
    if (ser_count >= MAX_COUNT) begin
      ser_ovf = 1'b1;
    end else begin
      ser_count++;
      ser_sx  += xs;
      ser_sy  += ys;
      ser_sxx += xs * xs;
      ser_syy += ys * ys;
      ser_sxy += xs * ys;
    end
    if (!last) return 0;
    res.corr   = '0;
    res.status = ST_OK;
    res.pairs  = ser_count[PAIR_W-1:0];
    if (ser_ovf) begin
      res.status = ST_OVERFLOW;
    end else begin
      n_w = ser_count;
      num = n_w * 128'(signed'(ser_sxy)) - 128'(signed'(ser_sx)) * 128'(signed'(ser_sy));
      dx  = n_w * 128'(signed'(ser_sxx)) - 128'(signed'(ser_sx)) * 128'(signed'(ser_sx));
      dy  = n_w * 128'(signed'(ser_syy)) - 128'(signed'(ser_sy)) * 128'(signed'(ser_sy));
      if (dx == 0 || dy == 0) begin
        res.status = ST_ZERO_VAR;
      end else begin
        mag  = num < 0 ? -num : num;
        root = root_floor(unsigned'(dx) * unsigned'(dy));
        quo  = (unsigned'(mag) << 15) / root;
        if (quo > 32768) quo = 32768;
        // Clamp positive at +32767; negative may reach -32768.
        if (num < 0) res.corr = -$signed({1'b0, quo[15:0]});
        else         res.corr = quo > 32767 ? 16'sd32767 : quo[15:0];
      end
    end
    clear_series();
    return 1;
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    $display("mismatch %s: expected %0d, got %0d at cycle %0d", field, want, got, cycles);
    errors++;
  endtask

  // Offer one request; hold it until taken, then fold it into the series.
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last,
                           logic typed = 1'b0, corr_result_t typed_res = '{0, ST_OK, 0});
    corr_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.x_sample <= x;
    in_if.y_sample <= y;
    in_if.last     <= last;
    do @(posedge clk); while (!in_if.ready);
    if (fold_pair(x, y, last, res)) pending_corr.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_corr.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    return 16'($urandom);
  endfunction

  // One series of random content, mostly short, with shaped correlation.
  task automatic send_series(int unsigned len);
    logic signed [15:0] x, y;
    int                 shape;
    int                 slope;
    shape = $urandom_range(5);
    slope = $urandom_range(8) - 4;
    for (int unsigned i = 0; i < len; i++) begin
      x = rand_sample();
      case (shape)
        0: y = rand_sample();
        1: y = 16'(x * slope / 4 + $signed($urandom_range(64)) - 32);
        2: y = -x;
        3: begin x = 16'sd1234; y = rand_sample(); end
        4: y = 16'($signed($urandom_range(7)) - 4);
        default: begin x = $urandom_range(1) ? -16'sd32768 : 16'sd32767; y = rand_sample(); end
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  // Accept results and compare them with the oldest prediction.
  always @(posedge clk) begin
    corr_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_corr.size() == 0) begin
          $display("unexpected result at cycle %0d", cycles);
          errors++;
        end else begin
          want = pending_corr.pop_front();
          if (out_if.corr_q15 !== want.corr)
            report_mismatch("corr_q15", want.corr, out_if.corr_q15);
          if (out_if.status !== want.status)
            report_mismatch("status", want.status, out_if.status);
          if (out_if.pair_count !== want.pairs)
            report_mismatch("pair_count", want.pairs, out_if.pair_count);
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(99) >= stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  stim_row_t directed_rows[] = '{
    // A lone pair has no variance.
    '{16'sd5, -16'sd7, 1'b1, 1'b1, '{16'sd0, ST_ZERO_VAR, 13'd1}},
    // Identical extremes: perfect correlation clamps at +32767.
    '{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd32767, 16'sd32767, 1'b1, 1'b1, '{16'sd32767, ST_OK, 13'd2}},
    // Mirrored extremes: perfect anticorrelation reaches -32768.
    '{-16'sd32768, 16'sd32767, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd32767, -16'sd32768, 1'b1, 1'b1, '{-16'sd32768, ST_OK, 13'd2}},
    // Constant x: zero variance in x.
    '{16'sd100, 16'sd1, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd100, 16'sd9, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd100, -16'sd3, 1'b1, 1'b1, '{16'sd0, ST_ZERO_VAR, 13'd3}},
    // Constant y: zero variance in y.
    '{-16'sd1, 16'sd0, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd0, 16'sd0, 1'b1, 1'b1, '{16'sd0, ST_ZERO_VAR, 13'd2}},
    // Mixed signs, checked against the predictor.
    '{16'sd1, 16'sd2, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{-16'sd1, 16'sd3, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd21845, -16'sd21846, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{-16'sd21846, 16'sd21845, 1'b1, 1'b0, '{0, ST_OK, 0}},
    '{-16'sd1, -16'sd1, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd2, 16'sd5, 1'b0, 1'b0, '{0, ST_OK, 0}},
    '{16'sd3, -16'sd32768, 1'b1, 1'b0, '{0, ST_OK, 0}}
  };

  initial begin
    int unsigned sent;
    int unsigned len;
    in_if.valid    = 1'b0;
    in_if.x_sample = '0;
    in_if.y_sample = '0;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    rst_n          = 1'b0;
    errors         = 0;
    cycles         = 0;
    stall_pct      = 0;
    idle_pct       = 0;
    hold_cycles    = 0;
    clear_series();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].res);
    drain_results();

    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      // Hold off the receiver while series keep coming so the unit backs up.
      if (phase == 0) hold_cycles = 3000;
      // One series past MAX_COUNT to reach the overflow status.
      if (phase == 2) send_series(MAX_COUNT + $urandom_range(3) + 1);
      // Count requests, not series, toward the budget of each phase.
      while (sent < 300 * (phase + 1)) begin
        case ($urandom_range(19))
          0, 1, 2: len = 1;
          3:       len = $urandom_range(200, 13);
          default: len = $urandom_range(12, 2);
        endcase
        send_series(len);
        sent += len;
        // Pause now and then until every pending result is out.
        if ($urandom_range(29) == 0) drain_results();
      end
    end

    drain_results();
    repeat (FINISH_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/pcorr_pkg.sv
design/pcorr_if.sv
design/pcorr_ctrl.sv
design/pcorr_datapath.sv
design/pearson_correlation_unit.sv
design/pcorr_checker.sv
tb/testbench.sv
